FILE: rtl/core/gbcc_pkg.sv
// Shared constants and types for the gyro bias calibration and correction block.
package gbcc_pkg;

    // Field widths
    localparam int RAW_W   = 16;   // raw gyro sample
    localparam int RATE_W  = 21;   // corrected rate, 4 fraction bits
    localparam int SENS_W  = 10;   // sensitivity register
    localparam int SHAKE_W = 8;    // shake limit register
    localparam int SUM_W   = 24;   // per-axis calibration sum
    localparam int OP_W    = 25;   // signed dividend into the divider
    localparam int MAG_W   = 24;   // dividend magnitude / quotient
    localparam int DIV_W   = 10;   // divisor width (covers sensitivity and sample count)
    localparam int DIV_STEPS = MAG_W / 2;   // two quotient bits per cycle
    localparam int STEP_W  = $clog2(DIV_STEPS + 1);

    // Bus widths
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 64;
    localparam int M_USER_W = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Defaults
    localparam int CAL_SAMPLES_DEF = 100;
    localparam logic [SENS_W-1:0]  SENS_RESET  = 10'd164;
    localparam logic [SHAKE_W-1:0] SHAKE_RESET = 8'd10;
    localparam int RATE_MAX = 1048560;

    // Register map: index taken from address bit 2
    localparam logic REG_SENS  = 1'b0;
    localparam logic REG_SHAKE = 1'b1;

    // Divider request and response
    typedef struct packed {
        logic                   start;
        logic signed [OP_W-1:0] dividend;
        logic [DIV_W-1:0]       divisor;
    } gbcc_div_req_t;

    typedef struct packed {
        logic             done;
        logic             neg;
        logic [MAG_W-1:0] quotient;
    } gbcc_div_resp_t;

endpackage

FILE: rtl/core/gbcc_div.sv
// Shared iterative signed divider, two restoring quotient bits per cycle.
module gbcc_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gbcc_pkg::gbcc_div_req_t  req,
    output gbcc_pkg::gbcc_div_resp_t resp
);
    import gbcc_pkg::*;

    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [MAG_W-1:0]  sh_reg;

    logic [OP_W-1:0]   mag;
    logic [DIV_W:0]    r1;
    logic [DIV_W:0]    r1s;
    logic [DIV_W:0]    r2;
    logic [DIV_W:0]    r2s;
    logic              ge1;
    logic              ge2;

    // Magnitude of the incoming dividend
    assign mag = req.dividend[OP_W-1] ? (~req.dividend + 1'b1) : req.dividend;

    // Two chained restoring steps
    always_comb
    begin
        r1  = {rem_reg, sh_reg[MAG_W-1]};
        ge1 = (r1 >= {1'b0, div_reg});
        r1s = ge1 ? (r1 - {1'b0, div_reg}) : r1;
        r2  = {r1s[DIV_W-1:0], sh_reg[MAG_W-2]};
        ge2 = (r2 >= {1'b0, div_reg});
        r2s = ge2 ? (r2 - {1'b0, div_reg}) : r2;
    end

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == STEP_W'(1));
            if (req.start)
                cnt_reg <= STEP_W'(DIV_STEPS);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Datapath: load magnitude, then shift quotient bits in at the bottom
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.dividend[OP_W-1];
            sh_reg  <= mag[MAG_W-1:0];
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= r2s[DIV_W-1:0];
            sh_reg  <= {sh_reg[MAG_W-3:0], ge1, ge2};
        end
    end

    assign resp.done     = done_reg;
    assign resp.neg      = neg_reg;
    assign resp.quotient = sh_reg;

endmodule

FILE: rtl/core/gyro_bias_calibrate_correct.sv
// Top level: gyro zero-bias calibration, bias correction and rate scaling.
//
//  channel   | dir | handshake                 | payload
//  ----------+-----+---------------------------+-----------------------------------
//  s_*       | in  | s_tvalid / s_tready       | x, y, z raw samples
//  m_*       | out | m_tvalid / m_tready       | x, y, z rates; tuser calibrating, shake
//  APB       | in  | psel, penable, pwrite     | sensitivity, shake limit
//
// A calibrating sample goes from the shake test straight to the output register. A corrected
// sample, and the sample that completes calibration, first makes three passes through
// the shared divider (prep, scale, start, divider steps, done, store), then goes to the output.
// One sample is in work at a time; s_tready is high only in idle.
// The next sample is accepted while a finished result waits in the output register.
// Reset clears sums, count and bias and starts a new calibration.
module gyro_bias_calibrate_correct #(
    parameter int CAL_SAMPLES = gbcc_pkg::CAL_SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gbcc_pkg::S_DATA_W-1:0] s_tdata,   // x_rate_raw, y_rate_raw, z_rate_raw
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gbcc_pkg::M_DATA_W-1:0] m_tdata,   // x_rate_dps, y_rate_dps, z_rate_dps, pad
    output logic [gbcc_pkg::M_USER_W-1:0] m_tuser,   // calibrating, shake_restart
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbcc_pkg::APB_AW-1:0]   paddr,
    input  logic [gbcc_pkg::APB_DW-1:0]   pwdata,
    output logic [gbcc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import gbcc_pkg::*;

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SHAKE = 8'b0000_0010,
        S_PREP  = 8'b0000_0100,
        S_SCALE = 8'b0000_1000,
        S_START = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_STORE = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [SENS_W-1:0]  sens_reg;
    logic [SHAKE_W-1:0] shake_reg;

    logic                   cal_done_reg;
    logic [CNT_W-1:0]       count_reg;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [RAW_W-1:0] bias_reg [3];
    logic [1:0]             axis_reg;
    logic                   cal_flag_reg;
    logic                   shake_flag_reg;

    logic signed [RAW_W-1:0]  raw_reg [3];
    logic signed [OP_W-1:0]   diff_reg;
    logic signed [OP_W-1:0]   scaled_reg;
    logic signed [RATE_W-1:0] rate_reg [3];

    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic [M_USER_W-1:0]   m_tuser_reg;

    gbcc_div_req_t  div_req;
    gbcc_div_resp_t div_resp;

    logic                   cfg_wr;
    logic                   accept;
    logic                   out_free;
    logic                   shake_hit;
    logic [RAW_W:0]         x_ext;
    logic [RAW_W:0]         x_mag;
    logic [19:0]            shake_lhs;
    logic [17:0]            shake_rhs;
    logic [CNT_W-1:0]       count_inc;
    logic signed [OP_W-1:0] diff_calc;
    logic [MAG_W-1:0]       q_sat;
    logic [RATE_W-1:0]      rate_mag;
    logic [RAW_W-1:0]       bias_mag;
    logic [DIV_W-1:0]       sens_div;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg  <= SENS_RESET;
            shake_reg <= SHAKE_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SENS)
                sens_reg <= pwdata[SENS_W-1:0];
            else
                shake_reg <= pwdata[SHAKE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SHAKE) ? APB_DW'(shake_reg) : APB_DW'(sens_reg);

    // Handshakes
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Shake test: |x| * 10 > limit * sensitivity
    assign x_ext     = {raw_reg[0][RAW_W-1], raw_reg[0]};
    assign x_mag     = x_ext[RAW_W] ? (~x_ext + 1'b1) : x_ext;
    assign shake_lhs = 20'(x_mag) * 20'd10;
    assign shake_rhs = 18'(shake_reg) * 18'(sens_reg);
    assign shake_hit = shake_lhs > 20'(shake_rhs);
    assign count_inc = count_reg + 1'b1;

    // Divider operand: sum plus half for the bias, raw minus bias for a rate
    assign diff_calc = cal_done_reg
        ? (OP_W'(raw_reg[axis_reg]) - OP_W'(bias_reg[axis_reg]))
        : (OP_W'(sum_reg[axis_reg]) + OP_W'(CAL_SAMPLES / 2));

    // Zero sensitivity divides by one
    assign sens_div = (sens_reg == '0) ? DIV_W'(1) : sens_reg;

    assign div_req.start    = (state_reg == S_START);
    assign div_req.dividend = scaled_reg;
    assign div_req.divisor  = cal_done_reg ? sens_div : DIV_W'(CAL_SAMPLES);

    gbcc_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .resp (div_resp)
    );

    // Quotient post-processing: saturate rates, truncate bias
    assign q_sat    = (div_resp.quotient > MAG_W'(RATE_MAX)) ? MAG_W'(RATE_MAX)
                                                             : div_resp.quotient;
    assign rate_mag = div_resp.neg ? (~q_sat[RATE_W-1:0] + 1'b1) : q_sat[RATE_W-1:0];
    assign bias_mag = div_resp.neg ? (~div_resp.quotient[RAW_W-1:0] + 1'b1)
                                   : div_resp.quotient[RAW_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = cal_done_reg ? S_PREP : S_SHAKE;
            S_SHAKE:
                if (shake_hit || (count_inc != CNT_W'(CAL_SAMPLES)))
                    state_next = S_OUT;
                else
                    state_next = S_PREP;
            S_PREP:
                state_next = S_SCALE;
            S_SCALE:
                state_next = S_START;
            S_START:
                state_next = S_DIV;
            S_DIV:
                if (div_resp.done)
                    state_next = S_STORE;
            S_STORE:
                state_next = (axis_reg == 2'd2) ? S_OUT : S_PREP;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control and calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cal_done_reg   <= 1'b0;
            count_reg      <= '0;
            axis_reg       <= '0;
            cal_flag_reg   <= 1'b0;
            shake_flag_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k]  <= '0;
                bias_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                    if (accept)
                    begin
                        cal_flag_reg   <= !cal_done_reg;
                        shake_flag_reg <= 1'b0;
                        axis_reg       <= '0;
                    end
                S_SHAKE:
                    if (shake_hit)
                    begin
                        shake_flag_reg <= 1'b1;
                        count_reg      <= '0;
                        for (int k = 0; k < 3; k++)
                            sum_reg[k] <= '0;
                    end
                    else
                    begin
                        count_reg <= count_inc;
                        for (int k = 0; k < 3; k++)
                            sum_reg[k] <= sum_reg[k] + SUM_W'(raw_reg[k]);
                    end
                S_STORE:
                begin
                    if (!cal_done_reg)
                        bias_reg[axis_reg] <= bias_mag;
                    if (axis_reg == 2'd2)
                    begin
                        if (!cal_done_reg)
                            cal_done_reg <= 1'b1;
                    end
                    else
                        axis_reg <= axis_reg + 1'b1;
                end
                default:
                    ;
            endcase

            // Output register
            if (state_reg == S_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg[0] <= s_tdata[RAW_W-1:0];
            raw_reg[1] <= s_tdata[2*RAW_W-1:RAW_W];
            raw_reg[2] <= s_tdata[3*RAW_W-1:2*RAW_W];
            for (int k = 0; k < 3; k++)
                rate_reg[k] <= '0;
        end
        if (state_reg == S_PREP)
            diff_reg <= diff_calc;
        // Scale by 160 = 128 + 32 for a rate
        if (state_reg == S_SCALE)
            scaled_reg <= cal_done_reg ? ((diff_reg <<< 7) + (diff_reg <<< 5)) : diff_reg;
        if (state_reg == S_STORE && cal_done_reg)
            rate_reg[axis_reg] <= rate_mag;
        if (state_reg == S_OUT && out_free)
        begin
            m_tdata_reg <= M_DATA_W'({rate_reg[2], rate_reg[1], rate_reg[0]});
            m_tuser_reg <= {shake_flag_reg, cal_flag_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/core/gbcc_checker.sv
// Port-level checker for the gyro bias block, bound to the top level.
module gbcc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gbcc_pkg::M_DATA_W-1:0] m_tdata,
    input logic [gbcc_pkg::M_USER_W-1:0] m_tuser
);
    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A calibrating result carries zero rates
    a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("nonzero rate during calibration");

    // Shake restart is only flagged while calibrating
    a_shake_cal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("shake flag after calibration");

    // One sample in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

endmodule

bind gyro_bias_calibrate_correct gbcc_checker u_gbcc_checker (.*);

FILE: verif/gyro_bias_calibrate_correct_test.sv
// Self-checking testbench for the gyro bias calibration and rate correction block.
module gyro_bias_calibrate_correct_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gbcc_pkg::*;

    localparam int TOTAL_ITEMS = 1950;
    localparam int STALL_LIMIT = 1000;   // cycles with no transaction before giving up
    localparam int END_DRAIN   = 100;    // cycles to watch for stray results at the end
    localparam logic [APB_AW-1:0] SENS_ADDR  = {REG_SENS, 2'b00};
    localparam logic [APB_AW-1:0] SHAKE_ADDR = {REG_SHAKE, 2'b00};

    // Expected contents of one output transaction
    typedef struct packed {
        logic              calibrating;
        logic              shake_restart;
        logic [RATE_W-1:0] rate_x;
        logic [RATE_W-1:0] rate_y;
        logic [RATE_W-1:0] rate_z;
    } gyro_rate_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // Register copies and calibration state of the predictor
    logic [SENS_W-1:0]     sens_cfg = SENS_RESET;
    logic [SHAKE_W-1:0]    shake_cfg = SHAKE_RESET;
    bit                    bias_ready = 1'b0;
    int                    good_count = 0;
    int                    axis_sum [3] = '{0, 0, 0};
    int                    axis_bias [3] = '{0, 0, 0};

    logic [S_DATA_W-1:0]   raw_pending [$];
    gyro_rate_t            rate_expect [$];
    int                    items_queued = 0;
    int                    errors = 0;
    int unsigned           src_gap_max = 7;
    int unsigned           snk_gap_max = 7;
    int unsigned           src_wait = 0;
    int unsigned           sink_wait = 0;
    int                    quiet_cycles = 0;

    gyro_bias_calibrate_correct dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Bias-corrected rate in deg/s with 4 fraction bits, saturated to the field
    function automatic logic [RATE_W-1:0] scale_rate(input int raw, input int bias);
        longint num;
        longint den;
        longint q;
        num = longint'(raw - bias) * 160;
        den = (sens_cfg == '0) ? 64'sd1 : longint'(sens_cfg);
        q = num / den;
        if (q > RATE_MAX)
            q = RATE_MAX;
        else if (q < -RATE_MAX)
            q = -RATE_MAX;
        return q[RATE_W-1:0];
    endfunction

    // Advance the calibration state by one sample and return its result
    function automatic gyro_rate_t track_sample(input logic [S_DATA_W-1:0] d);
        gyro_rate_t res;
        int         raw [3];
        longint     mag;
        longint     lhs;
        longint     rhs;
        res = '0;
        for (int k = 0; k < 3; k++)
            raw[k] = $signed(d[16*k +: 16]);
        if (bias_ready)
        begin
            res.rate_x = scale_rate(raw[0], axis_bias[0]);
            res.rate_y = scale_rate(raw[1], axis_bias[1]);
            res.rate_z = scale_rate(raw[2], axis_bias[2]);
            return res;
        end
        res.calibrating = 1'b1;
        // shake test on x only
        mag = (raw[0] < 0) ? -raw[0] : raw[0];
        lhs = mag * 10;
        rhs = longint'(shake_cfg) * longint'(sens_cfg);
        if (lhs > rhs)
        begin
            for (int k = 0; k < 3; k++)
                axis_sum[k] = 0;
            good_count = 0;
            res.shake_restart = 1'b1;
            return res;
        end
        for (int k = 0; k < 3; k++)
            axis_sum[k] += raw[k];
        good_count++;
        if (good_count >= CAL_SAMPLES_DEF)
        begin
            for (int k = 0; k < 3; k++)
                axis_bias[k] = (axis_sum[k] + CAL_SAMPLES_DEF / 2) / CAL_SAMPLES_DEF;
            bias_ready = 1'b1;
        end
        return res;
    endfunction

    // Raw axis value weighted toward the extremes and zero
    function automatic logic [15:0] raw_value();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 6)) - 16'd3;
            default: return 16'($urandom());
        endcase
    endfunction

    // x value that passes the shake test under the current registers
    function automatic logic [15:0] quiet_x();
        longint lim;
        int     v;
        lim = (longint'(shake_cfg) * longint'(sens_cfg)) / 10;
        if (lim > 32767)
            lim = 32767;
        v = $urandom_range(int'(lim), 0);
        if ($urandom_range(0, 7) == 0)
            v = int'(lim);
        return ($urandom_range(0, 1) != 0) ? 16'(-v) : 16'(v);
    endfunction

    // x value that fails the shake test under the current registers
    function automatic logic [15:0] shaky_x();
        int lo;
        int m;
        lo = int'((longint'(shake_cfg) * longint'(sens_cfg)) / 10) + 1;
        m = $urandom_range(32768, lo);
        if ($urandom_range(0, 7) == 0)
            m = lo;
        if (m == 32768)
            return 16'h8000;
        return ($urandom_range(0, 1) != 0) ? 16'(-m) : 16'(m);
    endfunction

    // Sensitivity choice: mostly in range, with the edges and values below range
    function automatic logic [SENS_W-1:0] pick_sens();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return SENS_W'($urandom_range(1, 9));
            2: return SENS_W'(10);
            3: return SENS_W'(1000);
            4: return '1;
            default: return SENS_W'($urandom_range(10, 1000));
        endcase
    endfunction

    task automatic push_sample(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        raw_pending.push_back({z, y, x});
        items_queued++;
    endtask

    // Wait until every queued sample is sent and every result has come back
    task automatic settle();
        do
            @(negedge clk);
        while (raw_pending.size() != 0 || s_tvalid || rate_expect.size() != 0);
    endtask

    // Register write: setup cycle, then access cycle
    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[2] == REG_SENS)
            sens_cfg = data[SENS_W-1:0];
        else
            shake_cfg = data[SHAKE_W-1:0];
    endtask

    // Drain, reprogram both registers (junk in the unused bits), pick idle modes
    task automatic begin_phase(input logic [SENS_W-1:0] sens, input logic [SHAKE_W-1:0] limit);
        settle();
        reg_write(SENS_ADDR, {22'($urandom()), sens});
        reg_write(SHAKE_ADDR, {24'($urandom()), limit});
        src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
        snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
    endtask

    task automatic check_field(input string name, input logic signed [RATE_W-1:0] want,
                               input logic signed [RATE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Sample source: one transaction per item, gap counted while the block is ready
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                rate_expect.push_back(track_sample(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (src_wait != 0)
                begin
                    if (s_tready)
                        src_wait <= src_wait - 1;
                    s_tvalid <= 1'b0;
                end
                else if (raw_pending.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= raw_pending.pop_front();
                    src_wait <= $urandom_range(0, src_gap_max);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Rate sink: check each result against the oldest expectation, then stall for a random gap that may be zero
    always @(posedge clk)
    begin : rate_sink
        gyro_rate_t  want;
        int unsigned hold;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (rate_expect.size() == 0)
            begin
                $display("%0t ns: unexpected result: expected none, actual tuser %b tdata %h",
                         $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                want = rate_expect.pop_front();
                check_field("calibrating", RATE_W'(want.calibrating), RATE_W'(m_tuser[0]));
                check_field("shake_restart", RATE_W'(want.shake_restart), RATE_W'(m_tuser[1]));
                check_field("x_rate_dps", want.rate_x, m_tdata[RATE_W-1:0]);
                check_field("y_rate_dps", want.rate_y, m_tdata[2*RATE_W-1:RATE_W]);
                check_field("z_rate_dps", want.rate_z, m_tdata[3*RATE_W-1:2*RATE_W]);
            end
            hold = $urandom_range(0, snk_gap_max);
            sink_wait <= hold;
            m_tready <= (hold == 0);
        end
        else if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1;
            m_tready <= (sink_wait == 1);
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pwrite))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("gyro_bias_calibrate_correct_test failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: shake threshold is |x| > 164
        push_sample(16'sd164, 16'sd32767, -16'sd32768);
        push_sample(16'sd165, 16'sd0, 16'sd0);
        push_sample(-16'sd164, -16'sd32768, 16'sd32767);
        push_sample(-16'sd165, 16'sd1, -16'sd1);
        push_sample(16'sd32767, 16'sd5, 16'sd5);
        push_sample(-16'sd32768, 16'sd5, 16'sd5);
        push_sample(16'sd0, 16'sd0, 16'sd0);

        // zero sensitivity: any nonzero x is a shake
        begin_phase('0, '1);
        push_sample(16'sd0, -16'sd1, 16'sd1);
        push_sample(16'sd1, 16'sd0, 16'sd0);
        push_sample(-16'sd1, 16'sd0, 16'sd0);

        // largest threshold: |x| > 26086
        begin_phase('1, '1);
        push_sample(16'sd26086, 16'sd100, -16'sd100);
        push_sample(16'sd26087, 16'sd0, 16'sd0);
        push_sample(-16'sd32768, 16'sd0, 16'sd0);

        // smallest nonzero threshold
        begin_phase(SENS_W'(1), SHAKE_W'(1));
        push_sample(16'sd0, 16'sd32767, 16'sd32767);
        push_sample(16'sd1, 16'sd0, 16'sd0);

        // calibration: interrupted runs, then a full run of quiet samples
        for (int r = 0; r < 4; r++)
        begin
            begin_phase(pick_sens(), SHAKE_W'($urandom_range(0, 255)));
            if (r == 3)
            begin
                repeat (CAL_SAMPLES_DEF)
                    push_sample(quiet_x(), raw_value(), raw_value());
            end
            else
            begin
                repeat ($urandom_range(1, CAL_SAMPLES_DEF - 1))
                begin
                    if ($urandom_range(0, 19) == 0)
                        push_sample(shaky_x(), raw_value(), raw_value());
                    else
                        push_sample(quiet_x(), raw_value(), raw_value());
                end
                push_sample(shaky_x(), raw_value(), raw_value());
            end
        end

        // corrected rates; large x must no longer restart anything
        while (items_queued < TOTAL_ITEMS)
        begin
            begin_phase(pick_sens(), SHAKE_W'($urandom_range(0, 255)));
            repeat ($urandom_range(20, 150))
                push_sample(raw_value(), raw_value(), raw_value());
        end

        settle();
        repeat (END_DRAIN) @(posedge clk);
        if (errors == 0)
            $display("gyro_bias_calibrate_correct_test passed");
        else
            $display("gyro_bias_calibrate_correct_test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/gbcc_pkg.sv
rtl/core/gbcc_div.sv
rtl/core/gyro_bias_calibrate_correct.sv
rtl/core/gbcc_checker.sv
verif/gyro_bias_calibrate_correct_test.sv
